[src/ssd_pkg.sv]
// Package for the seven-segment scan display unit: types, codes, font.
`timescale 1ns / 1ps
`default_nettype none
package ssd_pkg;

  localparam int DIGITS   = 8;
  localparam int DIGIT_W  = 3;
  localparam int NUM_W    = 32;
  localparam int RADIX_W  = 5;
  localparam int REM_W    = 4;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam logic [2:0] OP_SET_POINT    = 3'd0;
  localparam logic [2:0] OP_CLEAR_POINT  = 3'd1;
  localparam logic [2:0] OP_WRITE_GLYPH  = 3'd2;
  localparam logic [2:0] OP_WRITE_NUMBER = 3'd3;
  localparam logic [2:0] OP_SET_VISIBLE  = 3'd4;
  localparam logic [2:0] OP_SCAN         = 3'd5;

  localparam logic [7:0] POINT_BIT  = 8'h80;
  localparam logic [7:0] GLYPH_BITS = 8'h7F;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  typedef struct packed {
    logic [2:0]         operation;
    logic [2:0]         position;
    logic [4:0]         symbol;
    logic [NUM_W-1:0]   number;
    logic [RADIX_W-1:0] radix;
    logic               visible;
  } item_t;

  typedef struct packed {
    logic [2:0] digit_select;
    logic [7:0] segments;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_CLEAR
  } state_t;

  // 17-entry font; anything past it is blank
  function automatic logic [7:0] glyph_of(input logic [4:0] idx);
    logic [7:0] g;
    case (idx)
      5'd0:    g = 8'h3F;
      5'd1:    g = 8'h06;
      5'd2:    g = 8'h5B;
      5'd3:    g = 8'h4F;
      5'd4:    g = 8'h66;
      5'd5:    g = 8'h6D;
      5'd6:    g = 8'h7D;
      5'd7:    g = 8'h07;
      5'd8:    g = 8'h7F;
      5'd9:    g = 8'h6F;
      5'd10:   g = 8'h77;
      5'd11:   g = 8'h7C;
      5'd12:   g = 8'h39;
      5'd13:   g = 8'h5E;
      5'd14:   g = 8'h79;
      5'd15:   g = 8'h71;
      5'd16:   g = 8'h40;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

[src/ssd_divider.sv]
// Bit-serial restoring divider: 32-bit value by a radix of 2 to 16.
`timescale 1ns / 1ps
`default_nettype none
module ssd_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        go,
  input  wire logic [ssd_pkg::NUM_W-1:0]   dividend,
  input  wire logic [ssd_pkg::RADIX_W-1:0] divisor,
  output logic                             done,
  output logic [ssd_pkg::NUM_W-1:0]        quotient,
  output logic [ssd_pkg::REM_W-1:0]        remainder
);
  import ssd_pkg::*;

  logic                 running;
  logic [DIV_CNT_W-1:0] cnt;
  logic [NUM_W-1:0]     quo;
  logic [REM_W-1:0]     rem;
  logic [RADIX_W-1:0]   dvs;

  logic [REM_W:0]       rem_shift;
  logic                 ge;
  logic [REM_W:0]       rem_diff;
  logic [REM_W-1:0]     rem_next;
  logic [NUM_W-1:0]     quo_next;

  // one quotient bit per cycle, MSB first
  always_comb begin
    rem_shift = {rem, quo[NUM_W-1]};
    ge        = (rem_shift >= dvs);
    rem_diff  = rem_shift - dvs;
    rem_next  = ge ? rem_diff[REM_W-1:0] : rem_shift[REM_W-1:0];
    quo_next  = {quo[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(NUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end else if (go) begin
        running <= 1'b1;
        cnt     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (running) begin
      quo <= quo_next;
      rem <= rem_next;
    end else if (go) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule
`default_nettype wire

[src/seven_segment_scan_display_unit.sv]
// Top level of the seven-segment scan display unit: digit store and sequencer.
//
//   port      dir  role
//   command   in   item (operation, position, symbol, number, radix, visible)
//   start     in   item offered; taken when busy is low
//   busy      out  high while a number write runs
//   result    out  scan result (digit_select, segments)
//   strobe    out  result valid for this one cycle
//
// Point, glyph and visible writes and scans leave the unit idle; a scan result
// shows on the cycle after the item is taken. A number write does one
// division by the radix per digit in the single divider, writing each
// remainder digit as it is done, for up to eight digits, then clears
// the unused upper digits one per cycle. Reset clears the store and sets every
// digit visible.
`timescale 1ns / 1ps
`default_nettype none
module seven_segment_scan_display_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire ssd_pkg::item_t  command,
  output logic                 busy,
  output logic                 strobe,
  output ssd_pkg::result_t     result
);
  import ssd_pkg::*;

  state_t state, state_next;

  logic [7:0]           store [DIGITS];
  logic [DIGITS-1:0]    vis_flags;
  logic [DIGIT_W-1:0]   cnt;
  logic [DIGIT_W-1:0]   cnt_next;
  logic [RADIX_W-1:0]   base;

  logic                 accept;
  logic                 pos_ok;
  logic [DIGIT_W-1:0]   rd_addr;
  logic [7:0]           rd_data;

  logic                 wr_en;
  logic [DIGIT_W-1:0]   wr_addr;
  logic [7:0]           wr_data;
  logic                 vis_wr;
  logic                 scan_hit;
  logic [RADIX_W-1:0]   base_next;

  logic                 div_go;
  logic [NUM_W-1:0]     div_dividend;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quo;
  logic [REM_W-1:0]     div_rem;
  logic                 last_digit;

  assign accept     = start && (state == ST_IDLE);
  assign busy       = (state != ST_IDLE);
  assign pos_ok     = (int'(command.position) < DIGITS);
  assign rd_addr    = (state == ST_IDLE) ? command.position : cnt;
  assign rd_data    = store[rd_addr];
  assign last_digit = (cnt == DIGIT_W'(DIGITS - 1));

  always_comb begin
    if (command.radix < RADIX_MIN) begin
      base_next = RADIX_MIN;
    end else if (command.radix > RADIX_MAX) begin
      base_next = RADIX_MAX;
    end else begin
      base_next = command.radix;
    end
  end

  ssd_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (div_dividend),
    .divisor   ((state == ST_IDLE) ? base_next : base),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && command.operation == OP_WRITE_NUMBER) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          if (last_digit) begin
            state_next = ST_IDLE;
          end else if (div_quo == '0) begin
            state_next = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        if (last_digit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = rd_addr;
    wr_data      = rd_data;
    vis_wr       = 1'b0;
    scan_hit     = 1'b0;
    div_go       = 1'b0;
    div_dividend = div_quo;
    cnt_next     = cnt;
    case (state)
      ST_IDLE: begin
        cnt_next     = '0;
        div_dividend = command.number;
        if (accept) begin
          case (command.operation)
            OP_SET_POINT: begin
              wr_en   = pos_ok;
              wr_data = rd_data | POINT_BIT;
            end
            OP_CLEAR_POINT: begin
              wr_en   = pos_ok;
              wr_data = rd_data & GLYPH_BITS;
            end
            OP_WRITE_GLYPH: begin
              wr_en   = pos_ok;
              wr_data = (rd_data & POINT_BIT) | glyph_of(command.symbol);
            end
            OP_WRITE_NUMBER: div_go = 1'b1;
            OP_SET_VISIBLE:  vis_wr = pos_ok;
            OP_SCAN:         scan_hit = 1'b1;
            default: ;
          endcase
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          wr_en    = 1'b1;
          wr_data  = (rd_data & POINT_BIT) | glyph_of({1'b0, div_rem});
          cnt_next = cnt + 1'b1;
          // next digit only while quotient is nonzero and digits remain
          div_go   = !last_digit && (div_quo != '0);
        end
      end
      ST_CLEAR: begin
        wr_en    = 1'b1;
        wr_data  = 8'h00;
        cnt_next = cnt + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      vis_flags <= '1;
      strobe    <= 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
        store[i] <= 8'h00;
      end
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      strobe <= scan_hit;
      if (wr_en) begin
        store[wr_addr] <= wr_data;
      end
      if (vis_wr) begin
        vis_flags[command.position] <= command.visible;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base <= base_next;
    end
    if (scan_hit) begin
      result.digit_select <= command.position;
      result.segments     <= (pos_ok && vis_flags[command.position]) ? rd_data : 8'h00;
    end
  end

endmodule
`default_nettype wire
